[rtl/roc_pkg.sv]
// Shared constants, types and helper functions of the round-crop overlay compositor.
package roc_pkg;

   // Panel geometry
   localparam int DIM_BITS      = 10;
   localparam int COL_W         = DIM_BITS;          // column / row counters
   localparam int DIM_W         = DIM_BITS + 1;      // width / height, up to 2^DIM_BITS
   localparam int DY_W          = DIM_W + 1;         // doubled vertical distance
   localparam int SQ_W          = 2 * DY_W;          // squared distances
   localparam int RAD_W         = 2 * DIM_BITS + 1;  // square-root radicand
   localparam int BAND_ROWS_DEF = 8;

   localparam logic [DIM_W-1:0] PANEL_DEF = DIM_W'(480);
   localparam logic [DIM_W-1:0] DIM_MIN   = DIM_W'(2);
   localparam logic [DIM_W-1:0] DIM_MAX   = DIM_W'(1 << DIM_BITS);

   // Configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CROP   = 2'd2;

   // Controller to datapath commands
   typedef struct packed {
      logic load;       // latch pixel, normalize position
      logic geom;       // register squared radius and band distance
      logic sqrt_load;  // start root of the chord radicand
      logic sqrt_step;  // one root digit
      logic chord_fin;  // finish window from the root
      logic full_row;   // band misses the circle, window is the whole row
      logic emit;       // write result, advance position
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic hit;        // window of the current band is known
      logic d_pos;      // chord radicand is positive
      logic sqrt_last;  // this is the final root digit
      logic out_free;   // output register can take a result
   } stat_type;

   // Clamp a raw dimension register into [2, 2^DIM_BITS]
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v < DIM_MIN) begin
         r = DIM_MIN;
      end else if (v > DIM_MAX) begin
         r = DIM_MAX;
      end
      return r;
   endfunction

   // One channel: (f*a + b*(255-a) + 127) / 255, divide done by shift-add
   function automatic logic [5:0] blend_ch(input logic [5:0] f, input logic [5:0] b,
                                           input logic [7:0] a);
      logic [15:0] y;
      logic [15:0] q;
      y = 16'(f) * 16'(a) + 16'(b) * 16'(8'd255 - a) + 16'd127;
      q = (y + 16'd1 + (y >> 8)) >> 8;
      return q[5:0];
   endfunction

endpackage

[rtl/rgb565_overlay_round_crop_unit.sv]
// Top level of the RGB565 overlay compositor with round-panel band crop.
// A transfer goes from LOOK to EMIT when its band window is known; EMIT waits until the
// output register is free. One pixel is in work at a time; with crop on, the first pixel
// of a band also runs the 11-step bit-pair root of the band chord when it meets the circle.
// The result register is separate, so a new pixel is taken while a result waits.
// Reset (synchronous, high): 480x480 panel, crop off, position at column 0 row 0.
module rgb565_overlay_round_crop_unit
   import roc_pkg::*;
#(
   parameter int BAND_ROWS = BAND_ROWS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   // background_pixel[15:0], overlay_color[31:16], overlay_alpha[39:32]
   input  logic [39:0]          req_tdata,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // out_pixel[15:0], column[25:16], row[35:26], window_start[45:36],
   // window_end[56:46], zeros[63:57]
   output logic [63:0]          rsp_tdata,
   output logic                 rsp_tlast,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_data
);

   cmd_type          cmd;
   stat_type         stat;
   logic [15:0]      out_pixel;
   logic [COL_W-1:0] out_column, out_row, out_window_start;
   logic [DIM_W-1:0] out_window_end;
   logic             out_band_last;

   assign csr_ready = 1'b1;

   roc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   roc_dp #(
      .BAND_ROWS (BAND_ROWS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .bg_in            (req_tdata[15:0]),
      .fg_in            (req_tdata[31:16]),
      .alpha_in         (req_tdata[39:32]),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_tready       (rsp_tready),
      .rsp_tvalid       (rsp_tvalid),
      .out_pixel        (out_pixel),
      .out_column       (out_column),
      .out_row          (out_row),
      .out_window_start (out_window_start),
      .out_window_end   (out_window_end),
      .out_band_last    (out_band_last)
   );

   // Pack result fields
   assign rsp_tdata = {7'd0, out_window_end, out_window_start, out_row, out_column, out_pixel};
   assign rsp_tlast = out_band_last;

   // A shown pixel lies inside its own window
   a_in_window: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (out_column >= out_window_start) &&
                     ({1'b0, out_column} < out_window_end))
      else $error("result column outside its band window");

   // Window start is always even
   a_start_even: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !out_window_start[0])
      else $error("odd window start");

   // One pixel in flight: no transfer right after a transfer
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input taken while previous pixel still in work");

endmodule

[rtl/roc_dp.sv]
// Datapath: config registers, position counters, chord root unit, blender, output register.
module roc_dp
   import roc_pkg::*;
#(
   parameter int BAND_ROWS = BAND_ROWS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_data,
   input  logic [15:0]          bg_in,
   input  logic [15:0]          fg_in,
   input  logic [7:0]           alpha_in,
   input  cmd_type              cmd,
   output stat_type             stat,
   input  logic                 rsp_tready,
   output logic                 rsp_tvalid,
   output logic [15:0]          out_pixel,
   output logic [COL_W-1:0]     out_column,
   output logic [COL_W-1:0]     out_row,
   output logic [COL_W-1:0]     out_window_start,
   output logic [DIM_W-1:0]     out_window_end,
   output logic                 out_band_last
);

   localparam int OFF_W = (BAND_ROWS > 1) ? $clog2(BAND_ROWS) : 1;
   localparam logic [OFF_W-1:0] OFF_LAST  = OFF_W'(BAND_ROWS - 1);
   localparam logic [DIM_W:0]   BAND_SPAN = (DIM_W + 1)'(BAND_ROWS);
   localparam logic [RAD_W-1:0] BIT_TOP   = RAD_W'(1) << (2 * DIM_BITS);

   // Config registers
   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic             crop_ff, crop_in;

   // Position state
   logic [COL_W-1:0] col_ff, col_in;
   logic [COL_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] base_ff, base_in;
   logic [OFF_W-1:0] off_ff, off_in;

   // Pixel payload
   logic [15:0] bg_ff, fg_ff;
   logic [7:0]  alpha_ff;

   // Chord geometry and root unit
   logic [SQ_W-1:0]  r2sq_ff, dy2sq_ff;
   logic [RAD_W-1:0] rad_ff, rad_in;
   logic [RAD_W-1:0] root_ff, root_in;
   logic [RAD_W-1:0] bit_ff, bit_in;

   // Band window cache
   logic [COL_W-1:0] cstart_ff, cstart_in;
   logic [DIM_W-1:0] cend_ff, cend_in;
   logic             cvalid_ff, cvalid_in;
   logic [COL_W-1:0] cbase_ff, cbase_in;

   // Output register
   logic             ovalid_ff, ovalid_in;
   logic [15:0]      pix_ff;
   logic [COL_W-1:0] ocol_ff, orow_ff, ows_ff;
   logic [DIM_W-1:0] owe_ff;
   logic             olast_ff;

   logic [DIM_W-1:0] w, h;
   assign w = clamp_dim(width_ff);
   assign h = clamp_dim(height_ff);

   // Config writes; any write drops the cached band window
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      crop_in   = crop_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_WIDTH:  width_in  = csr_data;
            REG_HEIGHT: height_in = csr_data;
            REG_CROP:   crop_in   = csr_data[0];
            default:    ;
         endcase
      end
   end

   // Position normalization at transfer (panel may have shrunk)
   logic [COL_W-1:0] ncol;
   logic [DIM_W-1:0] nrow, nbase;
   logic [OFF_W-1:0] noff;
   always_comb begin
      ncol  = col_ff;
      nrow  = {1'b0, row_ff};
      nbase = {1'b0, base_ff};
      noff  = off_ff;
      if ({1'b0, col_ff} >= w) begin
         ncol = '0;
         nrow = {1'b0, row_ff} + 1'b1;
         if (off_ff == OFF_LAST) begin
            noff  = '0;
            nbase = nrow;
         end else begin
            noff = off_ff + 1'b1;
         end
      end
      if (nrow >= h) begin
         nrow  = '0;
         nbase = '0;
         noff  = '0;
      end
   end

   // Position advance after a pixel
   logic [DIM_W-1:0] acol, arow, abase;
   logic [OFF_W-1:0] aoff;
   always_comb begin
      acol  = {1'b0, col_ff} + 1'b1;
      arow  = {1'b0, row_ff};
      abase = {1'b0, base_ff};
      aoff  = off_ff;
      if (acol >= w) begin
         acol = '0;
         arow = {1'b0, row_ff} + 1'b1;
         if (arow >= h) begin
            arow  = '0;
            abase = '0;
            aoff  = '0;
         end else if (off_ff == OFF_LAST) begin
            aoff  = '0;
            abase = arow;
         end else begin
            aoff = off_ff + 1'b1;
         end
      end
   end

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      base_in = base_ff;
      off_in  = off_ff;
      if (cmd.load) begin
         col_in  = ncol;
         row_in  = nrow[COL_W-1:0];
         base_in = nbase[COL_W-1:0];
         off_in  = noff;
      end else if (cmd.emit) begin
         col_in  = acol[COL_W-1:0];
         row_in  = arow[COL_W-1:0];
         base_in = abase[COL_W-1:0];
         off_in  = aoff;
      end
   end

   // Band geometry in doubled coordinates
   logic [DIM_W:0]   ysum;
   logic [DIM_W:0]   yend;
   logic [COL_W-1:0] y1;
   logic [DIM_W-1:0] cx2, cy2, r2;
   logic [DY_W-1:0]  two_y0, two_y1, dy2;
   always_comb begin
      ysum   = {1'b0, 1'b0, base_ff} + BAND_SPAN;
      yend   = (ysum < {1'b0, h}) ? ysum : {1'b0, h};
      y1     = COL_W'(yend - 1'b1);
      cx2    = w - 1'b1;
      cy2    = h - 1'b1;
      r2     = (w < h) ? w : h;
      two_y0 = {1'b0, base_ff, 1'b0};
      two_y1 = {1'b0, y1, 1'b0};
      if ({1'b0, cy2} < two_y0) begin
         dy2 = two_y0 - {1'b0, cy2};
      end else if ({1'b0, cy2} > two_y1) begin
         dy2 = {1'b0, cy2} - two_y1;
      end else begin
         dy2 = '0;
      end
   end

   // Radicand r^2 - dy^2, signed
   logic signed [SQ_W:0] dval;
   assign dval = $signed({1'b0, r2sq_ff}) - $signed({1'b0, dy2sq_ff});

   // Root unit: one bit pair per step
   logic [RAD_W:0] trial;
   always_comb begin
      trial   = {1'b0, root_ff} + {1'b0, bit_ff};
      rad_in  = rad_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      if (cmd.sqrt_load) begin
         rad_in  = dval[RAD_W-1:0];
         root_in = '0;
         bit_in  = BIT_TOP;
      end else if (cmd.sqrt_step) begin
         if ({1'b0, rad_ff} >= trial) begin
            rad_in  = rad_ff - trial[RAD_W-1:0];
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in = bit_ff >> 2;
      end
   end

   // Chord window from the root: start even, end rounded up to even, then clamped to the width
   logic [DIM_W-1:0]        q;
   logic [DIM_W:0]          cceil;
   logic signed [DIM_W+1:0] t;
   logic [COL_W-1:0]        x0;
   logic [DIM_W:0]          x1a, x1b;
   logic [DIM_W-1:0]        x1;
   always_comb begin
      q     = root_ff[DIM_W-1:0];
      cceil = {1'b0, q} + {{DIM_W{1'b0}}, (rad_ff != '0)};
      t     = $signed({2'b00, cx2}) - $signed({1'b0, cceil});
      x0    = (t > 0) ? COL_W'(t >>> 1) : '0;
      x0[0] = 1'b0;
      x1a   = (({1'b0, cx2} + {1'b0, q}) >> 1) + 1'b1;
      if (x1a > {1'b0, w}) begin
         x1a = {1'b0, w};
      end
      x1b = x1a[0] ? x1a + 1'b1 : x1a;
      x1  = (x1b > {1'b0, w}) ? w : x1b[DIM_W-1:0];
   end

   always_comb begin
      cstart_in = cstart_ff;
      cend_in   = cend_ff;
      cvalid_in = cvalid_ff;
      cbase_in  = cbase_ff;
      if (csr_we) begin
         cvalid_in = 1'b0;
      end else if (cmd.chord_fin) begin
         cstart_in = x0;
         cend_in   = x1;
         cvalid_in = 1'b1;
         cbase_in  = base_ff;
      end else if (cmd.full_row) begin
         cstart_in = '0;
         cend_in   = w;
         cvalid_in = 1'b1;
         cbase_in  = base_ff;
      end
   end

   // Window test and result fields
   logic [COL_W-1:0] ws;
   logic [DIM_W-1:0] we;
   logic             in_win, is_last;
   logic [15:0]      blended;
   logic [5:0]       ch_r, ch_g, ch_b;
   always_comb begin
      ws      = crop_ff ? cstart_ff : '0;
      we      = crop_ff ? cend_ff : w;
      in_win  = (col_ff >= ws) && ({1'b0, col_ff} < we);
      is_last = ({1'b0, col_ff} == we - 1'b1) && (row_ff == y1);
      ch_r    = blend_ch({1'b0, fg_ff[15:11]}, {1'b0, bg_ff[15:11]}, alpha_ff);
      ch_g    = blend_ch(fg_ff[10:5], bg_ff[10:5], alpha_ff);
      ch_b    = blend_ch({1'b0, fg_ff[4:0]}, {1'b0, bg_ff[4:0]}, alpha_ff);
      blended = {ch_r[4:0], ch_g, ch_b[4:0]};
   end

   // Output register valid
   always_comb begin
      ovalid_in = ovalid_ff;
      if (cmd.emit && in_win) begin
         ovalid_in = 1'b1;
      end else if (rsp_tready) begin
         ovalid_in = 1'b0;
      end
   end

   // Status
   always_comb begin
      stat.hit       = !crop_ff || (cvalid_ff && (cbase_ff == base_ff));
      stat.d_pos     = !dval[SQ_W] && (dval != '0);
      stat.sqrt_last = bit_ff[0];
      stat.out_free  = !ovalid_ff || rsp_tready;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= PANEL_DEF;
         height_ff <= PANEL_DEF;
         crop_ff   <= 1'b0;
         col_ff    <= '0;
         row_ff    <= '0;
         base_ff   <= '0;
         off_ff    <= '0;
         cstart_ff <= '0;
         cend_ff   <= '0;
         cvalid_ff <= 1'b0;
         cbase_ff  <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         crop_ff   <= crop_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         base_ff   <= base_in;
         off_ff    <= off_in;
         cstart_ff <= cstart_in;
         cend_ff   <= cend_in;
         cvalid_ff <= cvalid_in;
         cbase_ff  <= cbase_in;
         ovalid_ff <= ovalid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         bg_ff    <= bg_in;
         fg_ff    <= fg_in;
         alpha_ff <= alpha_in;
      end
      if (cmd.geom) begin
         r2sq_ff  <= SQ_W'(r2) * SQ_W'(r2);
         dy2sq_ff <= SQ_W'(dy2) * SQ_W'(dy2);
      end
      rad_ff  <= rad_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
      if (cmd.emit && in_win) begin
         pix_ff   <= blended;
         ocol_ff  <= col_ff;
         orow_ff  <= row_ff;
         ows_ff   <= ws;
         owe_ff   <= we;
         olast_ff <= is_last;
      end
   end

   assign rsp_tvalid       = ovalid_ff;
   assign out_pixel        = pix_ff;
   assign out_column       = ocol_ff;
   assign out_row          = orow_ff;
   assign out_window_start = ows_ff;
   assign out_window_end   = owe_ff;
   assign out_band_last    = olast_ff;

endmodule

[rtl/roc_ctrl.sv]
// Controller: sequences transfer, band window lookup, chord root and result write.
module roc_ctrl
   import roc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LOOK = 3'd1;
   localparam logic [2:0] ST_DIFF = 3'd2;
   localparam logic [2:0] ST_SQRT = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;
   localparam logic [2:0] ST_EMIT = 3'd5;

   logic [2:0] state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (stat.hit) begin
               state_in = ST_EMIT;
            end else begin
               cmd.geom = 1'b1;
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            if (stat.d_pos) begin
               cmd.sqrt_load = 1'b1;
               state_in      = ST_SQRT;
            end else begin
               cmd.full_row = 1'b1;
               state_in     = ST_EMIT;
            end
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (stat.sqrt_last) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            cmd.chord_fin = 1'b1;
            state_in      = ST_EMIT;
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

endmodule
